>>> rtl/dtsf_pkg.sv
// dtsf_pkg: shared types and constants for the decimal text to scaled fixed core.
// No dependencies; used by every rtl module and the checker.
package dtsf_pkg;

   localparam int SCALE_W = 5;
   localparam int INT_W   = 63;
   localparam int FRAC_W  = 60;
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 8;

   localparam logic [SCALE_W-1:0] MAX_SCALE_EXP = 5'd18;
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 5'd4;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      ST_PARSE,
      ST_SCALE,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic               take;
      logic               step;
      logic               step_frac;
      logic               finish;
      logic [SCALE_W-1:0] scale;
   } cmd_type;

   typedef struct packed {
      logic [SCALE_W-1:0] frac_count;
   } status_type;

endpackage

>>> rtl/dtsf_ctrl.sv
// dtsf_ctrl: sequencer for parse, scale steps and result store; holds the scale register.
// Depends on dtsf_pkg.
module dtsf_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_last_char,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dtsf_pkg::SCALE_W-1:0] csr_scale_exp,
   output dtsf_pkg::cmd_type            cmd,
   input  dtsf_pkg::status_type         status
);

   dtsf_pkg::state_type           state_ff, state_in;
   logic [dtsf_pkg::SCALE_W-1:0]  step_ff, step_in;
   logic [dtsf_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dtsf_pkg::SCALE_W-1:0]  scale_eff;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign scale_eff = (scale_ff > dtsf_pkg::MAX_SCALE_EXP) ?
                      dtsf_pkg::MAX_SCALE_EXP : scale_ff;

   always_comb begin
      scale_in = scale_ff;
      if (csr_valid) begin
         scale_in = csr_scale_exp;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req_ready     = 1'b0;
      cmd.take      = 1'b0;
      cmd.step      = 1'b0;
      cmd.step_frac = 1'b0;
      cmd.finish    = 1'b0;
      cmd.scale     = scale_eff;
      unique case (state_ff)
         dtsf_pkg::ST_PARSE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && req_last_char) begin
               step_in  = '0;
               state_in = dtsf_pkg::ST_SCALE;
            end
         end
         dtsf_pkg::ST_SCALE: begin
            if (step_ff == scale_eff) begin
               state_in = dtsf_pkg::ST_STORE;
            end else begin
               cmd.step      = 1'b1;
               cmd.step_frac = (step_ff >= status.frac_count);
               step_in       = step_ff + 5'd1;
            end
         end
         dtsf_pkg::ST_STORE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = dtsf_pkg::ST_PARSE;
            end
         end
         default: begin
            state_in = dtsf_pkg::ST_PARSE;
         end
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtsf_pkg::ST_PARSE;
         step_ff      <= '0;
         scale_ff     <= dtsf_pkg::SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/dtsf_datapath.sv
// dtsf_datapath: character parser state, accumulators, times-ten scaling and result register.
// Depends on dtsf_pkg.
module dtsf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dtsf_pkg::CHAR_W-1:0]  req_character,
   input  logic                         req_last_char,
   input  dtsf_pkg::cmd_type            cmd,
   output dtsf_pkg::status_type         status,
   output logic signed [dtsf_pkg::VALUE_W-1:0] rsp_scaled_value,
   output logic                         rsp_valid_res
);

   logic                          at_start_ff, at_start_in;
   logic                          frac_phase_ff, frac_phase_in;
   logic                          neg_ff, neg_in;
   logic [dtsf_pkg::INT_W-1:0]    int_ff, int_in;
   logic                          saw_ff, saw_in;
   logic [dtsf_pkg::FRAC_W-1:0]   frac_ff, frac_in;
   logic [dtsf_pkg::SCALE_W-1:0]  fcnt_ff, fcnt_in;
   logic                          failed_ff, failed_in;
   logic [dtsf_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                          res_ff, res_in;

   logic                          is_digit;
   logic [3:0]                    addend;
   logic [dtsf_pkg::INT_W+3:0]    int_prod;
   logic                          int_ovf;
   logic [dtsf_pkg::FRAC_W-1:0]   frac_prod;
   logic [dtsf_pkg::VALUE_W-1:0]  sum;
   logic [dtsf_pkg::VALUE_W-1:0]  mag;
   logic                          ok;

   assign is_digit = (req_character >= dtsf_pkg::CHAR_ZERO) &&
                     (req_character <= dtsf_pkg::CHAR_NINE);
   assign addend   = (cmd.take && is_digit) ? req_character[3:0] : 4'd0;

   assign int_prod  = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1) +
                      {{(dtsf_pkg::INT_W){1'b0}}, addend};
   assign int_ovf   = (int_prod[dtsf_pkg::INT_W+3:dtsf_pkg::INT_W] != 4'd0);
   assign frac_prod = (frac_ff << 3) + (frac_ff << 1) +
                      {{(dtsf_pkg::FRAC_W-4){1'b0}}, addend};

   assign sum = {1'b0, int_ff} + {4'd0, frac_ff};
   assign mag = {1'b0, sum[dtsf_pkg::VALUE_W-2:0]};
   assign ok  = !failed_ff && saw_ff && (fcnt_ff <= cmd.scale) && !sum[dtsf_pkg::VALUE_W-1];

   assign status.frac_count = fcnt_ff;
   assign rsp_scaled_value  = value_ff;
   assign rsp_valid_res     = res_ff;

   always_comb begin
      at_start_in   = at_start_ff;
      frac_phase_in = frac_phase_ff;
      neg_in        = neg_ff;
      int_in        = int_ff;
      saw_in        = saw_ff;
      frac_in       = frac_ff;
      fcnt_in       = fcnt_ff;
      failed_in     = failed_ff;
      value_in      = value_ff;
      res_in        = res_ff;

      if (cmd.take) begin
         at_start_in = 1'b0;
         if (!failed_ff) begin
            priority if (at_start_ff && (req_character == dtsf_pkg::CHAR_PLUS ||
                                         req_character == dtsf_pkg::CHAR_MINUS)) begin
               neg_in = (req_character == dtsf_pkg::CHAR_MINUS);
               if (req_last_char) begin
                  failed_in = 1'b1;
               end
            end else if (!frac_phase_ff && is_digit) begin
               saw_in = 1'b1;
               if (int_ovf) begin
                  failed_in = 1'b1;
               end else begin
                  int_in = int_prod[dtsf_pkg::INT_W-1:0];
               end
            end else if (!frac_phase_ff && req_character == dtsf_pkg::CHAR_POINT) begin
               if (!saw_ff) begin
                  failed_in = 1'b1;
               end else begin
                  frac_phase_in = 1'b1;
               end
            end else if (frac_phase_ff && is_digit) begin
               if (fcnt_ff < cmd.scale) begin
                  frac_in = frac_prod;
                  fcnt_in = fcnt_ff + 5'd1;
               end
            end else begin
               failed_in = 1'b1;
            end
         end
      end

      if (cmd.step) begin
         if (int_ovf) begin
            failed_in = 1'b1;
         end else begin
            int_in = int_prod[dtsf_pkg::INT_W-1:0];
         end
         if (cmd.step_frac) begin
            frac_in = frac_prod;
         end
      end

      if (cmd.finish) begin
         res_in        = ok;
         value_in      = !ok ? '0 : (neg_ff ? (~mag + 64'd1) : mag);
         at_start_in   = 1'b1;
         frac_phase_in = 1'b0;
         neg_in        = 1'b0;
         int_in        = '0;
         saw_in        = 1'b0;
         frac_in       = '0;
         fcnt_in       = '0;
         failed_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff   <= 1'b1;
         frac_phase_ff <= 1'b0;
         neg_ff        <= 1'b0;
         int_ff        <= '0;
         saw_ff        <= 1'b0;
         frac_ff       <= '0;
         fcnt_ff       <= '0;
         failed_ff     <= 1'b0;
      end else begin
         at_start_ff   <= at_start_in;
         frac_phase_ff <= frac_phase_in;
         neg_ff        <= neg_in;
         int_ff        <= int_in;
         saw_ff        <= saw_in;
         frac_ff       <= frac_in;
         fcnt_ff       <= fcnt_in;
         failed_ff     <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      res_ff   <= res_in;
   end

endmodule

>>> rtl/decimal_text_to_scaled_fixed_core.sv
// decimal_text_to_scaled_fixed_core: top level, controller plus datapath.
// Depends on dtsf_pkg, dtsf_ctrl, dtsf_datapath.
//
//   channel   prefix  direction  beat
//   request   req_    in         one ASCII character, last_char marks the end
//   response  rsp_    out        scaled_value, valid_res, one per number
//   register  csr_    in         scale_exp (decimal exponent, reset 4)
//
// A character that is not last is taken whenever req_ready is high. After a last
// character, req_ready stays low through one times-ten step per scale digit on
// the shift-add units shared with parsing, the state that closes the steps and
// the load of the result register; the load also waits for an earlier held result.
// Characters of the next number are taken while a result waits on rsp_ready.
// Reset is synchronous and sets the scale to 4.
module decimal_text_to_scaled_fixed_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dtsf_pkg::CHAR_W-1:0]         req_character,
   input  logic                                req_last_char,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dtsf_pkg::VALUE_W-1:0] rsp_scaled_value,
   output logic                                rsp_valid_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dtsf_pkg::SCALE_W-1:0]        csr_scale_exp
);

   dtsf_pkg::cmd_type    cmd;
   dtsf_pkg::status_type status;

   dtsf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_scale_exp    (csr_scale_exp),
      .cmd              (cmd),
      .status           (status)
   );

   dtsf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_character    (req_character),
      .req_last_char    (req_last_char),
      .cmd              (cmd),
      .status           (status),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_valid_res    (rsp_valid_res)
   );

endmodule

>>> rtl/dtsf_checker.sv
// dtsf_checker: port-level assertions for the core, bound to the top level.
// Depends on dtsf_pkg and decimal_text_to_scaled_fixed_core.
module dtsf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last_char,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [dtsf_pkg::VALUE_W-1:0] rsp_scaled_value,
   input logic                                rsp_valid_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_scaled_value == '0)
      else $error("failed result carries a nonzero value");

   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_scaled_value != {1'b1, {(dtsf_pkg::VALUE_W-1){1'b0}}})
      else $error("result is the most negative value");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_char |=> !req_ready)
      else $error("request taken during scaling");

   a_store_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result loaded while parsing");

endmodule

bind decimal_text_to_scaled_fixed_core dtsf_checker u_dtsf_checker (.*);
